// ===== rtl/agcs_pkg.sv =====
// Shared constants, types and arithmetic helpers for the gravity-compensated setpoint block.
`default_nettype none
package agcs_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int N_JOINTS        = 4;
    localparam int STIFF_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CORDIC_ITERS    = 30;
    localparam int CORDIC_LAT      = CORDIC_ITERS + 2;
    localparam int TORQUE_LAT      = 5;
    localparam int Z_W             = 35;
    localparam int XY_W            = 34;
    localparam int TRIG_W          = 33;
    localparam int TORQ_W          = 34;
    localparam int DIV_NW          = 43;
    localparam int DIV_DW          = 39;

    typedef logic        [STIFF_W-1:0] t_stiff;
    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef logic signed [TORQ_W-1:0]  t_torque;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_stiff                STIFF_RESET = 16'd2048;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
    localparam t_trig                 COEF_A      = 33'sd1546304191;
    localparam t_trig                 COEF_B      = 33'sd648857889;

    localparam t_cfg_idx REG_STIFF_J1 = 2'd0;
    localparam t_cfg_idx REG_STIFF_J2 = 2'd1;
    localparam t_cfg_idx REG_STIFF_J3 = 2'd2;
    localparam t_cfg_idx REG_STIFF_J4 = 2'd3;

    function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 35'sh3243F6A8;
            1:  v = 35'sh1DAC6705;
            2:  v = 35'sh0FADBAFC;
            3:  v = 35'sh07F56EA6;
            4:  v = 35'sh03FEAB76;
            5:  v = 35'sh01FFD55B;
            6:  v = 35'sh00FFFAAA;
            7:  v = 35'sh007FFF55;
            8:  v = 35'sh003FFFEA;
            9:  v = 35'sh001FFFFD;
            10: v = 35'sh000FFFFF;
            11: v = 35'sh0007FFFF;
            12: v = 35'sh0003FFFF;
            13: v = 35'sh0001FFFF;
            14: v = 35'sh0000FFFF;
            15: v = 35'sh00007FFF;
            16: v = 35'sh00003FFF;
            17: v = 35'sh00001FFF;
            18: v = 35'sh00000FFF;
            19: v = 35'sh000007FF;
            20: v = 35'sh000003FF;
            21: v = 35'sh000001FF;
            22: v = 35'sh000000FF;
            23: v = 35'sh0000007F;
            24: v = 35'sh0000003F;
            25: v = 35'sh0000001F;
            26: v = 35'sh0000000F;
            27: v = 35'sh00000008;
            28: v = 35'sh00000004;
            29: v = 35'sh00000002;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q30 product with floor rounding.
    function automatic t_trig mul30(input t_trig a, input t_trig b);
        logic signed [2*TRIG_W-1:0] p;
        p = a * b;
        return p[TRIG_W+29:30];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/agcs_in_if.sv =====
// Input channel carrying the four joint reference angles.
`default_nettype none
interface agcs_in_if #(parameter int AW = agcs_pkg::ANGLE_WIDTH_DEF) ();
    logic                 valid;
    logic                 ready;
    logic signed [AW-1:0] angle_1;
    logic signed [AW-1:0] angle_2;
    logic signed [AW-1:0] angle_3;
    logic signed [AW-1:0] angle_4;

    modport source (output valid, output angle_1, output angle_2, output angle_3,
                    output angle_4, input ready);
    modport sink (input valid, input angle_1, input angle_2, input angle_3,
                  input angle_4, output ready);
endinterface
`default_nettype wire

// ===== rtl/agcs_out_if.sv =====
// Output channel carrying the compensated angles and the saturation flag.
`default_nettype none
interface agcs_out_if #(parameter int AW = agcs_pkg::ANGLE_WIDTH_DEF) ();
    logic                 valid;
    logic                 ready;
    logic signed [AW-1:0] comp_1;
    logic signed [AW-1:0] comp_2;
    logic signed [AW-1:0] comp_3;
    logic signed [AW-1:0] comp_4;
    logic                 saturated;

    modport source (output valid, output comp_1, output comp_2, output comp_3,
                    output comp_4, output saturated, input ready);
    modport sink (input valid, input comp_1, input comp_2, input comp_3,
                  input comp_4, input saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/agcs_cordic.sv =====
// Pipelined rotation-mode CORDIC lane producing the cosine and sine of one joint angle.
`default_nettype none
module agcs_cordic #(
    parameter int AW = agcs_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_angle,
    output agcs_pkg::t_trig      o_cos,
    output agcs_pkg::t_trig      o_sin,
    output logic signed [AW-1:0] o_angle
);
    import agcs_pkg::*;

    localparam int SH  = 33 - AW;
    localparam int NST = CORDIC_ITERS;

    logic signed [XY_W-1:0] r_x   [NST+1];
    logic signed [XY_W-1:0] r_y   [NST+1];
    logic signed [Z_W-1:0]  r_z   [NST+1];
    logic                   r_neg [NST+1];
    logic signed [AW-1:0]   r_ang [NST+1];

    logic signed [Z_W-1:0]  z_ext;
    logic signed [Z_W-1:0]  n_z0;
    logic                   n_neg0;
    logic signed [XY_W-1:0] n_cos;
    logic signed [XY_W-1:0] n_sin;
    t_trig                  r_cos;
    t_trig                  r_sin;
    logic signed [AW-1:0]   r_ang_out;

    always_comb begin
        z_ext = {{(Z_W-AW){i_angle[AW-1]}}, i_angle} << SH;
        if (z_ext > HALF_PI_Q30) begin
            n_z0   = z_ext - PI_Q30;
            n_neg0 = 1'b1;
        end else if (z_ext < -HALF_PI_Q30) begin
            n_z0   = z_ext + PI_Q30;
            n_neg0 = 1'b1;
        end else begin
            n_z0   = z_ext;
            n_neg0 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
            r_ang[0] <= i_angle;
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q30(i);
                end
                r_neg[i+1] <= r_neg[i];
                r_ang[i+1] <= r_ang[i];
            end
        end
    end

    assign n_cos = r_neg[NST] ? -r_x[NST] : r_x[NST];
    assign n_sin = r_neg[NST] ? -r_y[NST] : r_y[NST];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos     <= n_cos[TRIG_W-1:0];
            r_sin     <= n_sin[TRIG_W-1:0];
            r_ang_out <= r_ang[NST];
        end
    end

    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_angle = r_ang_out;
endmodule
`default_nettype wire

// ===== rtl/agcs_torque.sv =====
// Pipelined gravity torque computation shared by all four joints.
`default_nettype none
module agcs_torque #(
    parameter int AW = agcs_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  agcs_pkg::t_trig      i_cos    [agcs_pkg::N_JOINTS],
    input  agcs_pkg::t_trig      i_sin    [agcs_pkg::N_JOINTS],
    input  logic signed [AW-1:0] i_angle  [agcs_pkg::N_JOINTS],
    output agcs_pkg::t_torque    o_torque [agcs_pkg::N_JOINTS],
    output logic signed [AW-1:0] o_angle  [agcs_pkg::N_JOINTS]
);
    import agcs_pkg::*;

    logic signed [AW-1:0] r_ang [TORQUE_LAT][N_JOINTS];

    t_trig r_p01, r_p02, r_p03, r_p04, r_p05, r_p06, r_p07, r_p08, r_p09;
    t_trig r_s1 [N_JOINTS];
    t_trig r_t0a2, r_t1a2, r_q1, r_q2, r_q3, r_q4, r_q5, r_q6, r_q7, r_q8, r_q9;
    t_trig r_s2_2, r_s2_3;
    t_trig r_t0a3, r_t1a3, r_t0b3, r_t0c3, r_r1, r_t1b3, r_r2, r_r3, r_t2b3;
    t_trig r_t3a3, r_t3b3, r_r4;
    t_trig r_t0a4, r_t0b4, r_t0c4, r_t0d4, r_t1a4, r_t1b4, r_t1c4;
    t_trig r_t2a4, r_t2b4, r_t3a4, r_t3b4, r_t3c4;
    t_torque r_torq [N_JOINTS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < N_JOINTS; j++) begin
                r_ang[0][j] <= i_angle[j];
                r_s1[j]     <= i_sin[j];
            end
            for (int k = 1; k < TORQUE_LAT; k++) begin
                for (int j = 0; j < N_JOINTS; j++) begin
                    r_ang[k][j] <= r_ang[k-1][j];
                end
            end

            r_p01 <= mul30(i_cos[1], i_sin[0]);
            r_p02 <= mul30(i_cos[1], i_cos[3]);
            r_p03 <= mul30(i_cos[0], i_cos[2]);
            r_p04 <= mul30(i_sin[0], i_sin[1]);
            r_p05 <= mul30(i_cos[0], i_sin[1]);
            r_p06 <= mul30(i_cos[0], i_cos[3]);
            r_p07 <= mul30(i_cos[0], i_cos[1]);
            r_p08 <= mul30(i_sin[0], i_sin[2]);
            r_p09 <= mul30(i_cos[2], i_cos[3]);

            r_t0a2 <= mul30(COEF_A, r_p01);
            r_q1   <= mul30(r_p02, r_s1[0]);
            r_q2   <= mul30(r_p03, r_s1[3]);
            r_q3   <= mul30(r_p04, r_s1[2]);
            r_t1a2 <= mul30(COEF_A, r_p05);
            r_q4   <= mul30(r_p06, r_s1[1]);
            r_q5   <= mul30(r_p07, r_s1[2]);
            r_q6   <= mul30(r_p03, r_s1[1]);
            r_q7   <= mul30(r_p08, r_s1[3]);
            r_q8   <= mul30(r_p07, r_s1[3]);
            r_q9   <= mul30(r_p09, r_s1[0]);
            r_s2_2 <= r_s1[2];
            r_s2_3 <= r_s1[3];

            r_t0a3 <= r_t0a2;
            r_t1a3 <= r_t1a2;
            r_t0b3 <= mul30(COEF_B, r_q1);
            r_t0c3 <= mul30(COEF_B, r_q2);
            r_r1   <= mul30(r_q3, r_s2_3);
            r_t1b3 <= mul30(COEF_B, r_q4);
            r_r2   <= mul30(r_q5, r_s2_3);
            r_r3   <= mul30(r_q6, r_s2_3);
            r_t2b3 <= mul30(COEF_B, r_q7);
            r_t3a3 <= mul30(COEF_B, r_q8);
            r_t3b3 <= mul30(COEF_B, r_q9);
            r_r4   <= mul30(r_q4, r_s2_2);

            r_t0a4 <= r_t0a3;
            r_t0b4 <= r_t0b3;
            r_t0c4 <= r_t0c3;
            r_t0d4 <= mul30(COEF_B, r_r1);
            r_t1a4 <= r_t1a3;
            r_t1b4 <= r_t1b3;
            r_t1c4 <= mul30(COEF_B, r_r2);
            r_t2a4 <= mul30(COEF_B, r_r3);
            r_t2b4 <= r_t2b3;
            r_t3a4 <= r_t3a3;
            r_t3b4 <= r_t3b3;
            r_t3c4 <= mul30(COEF_B, r_r4);

            r_torq[0] <= t_torque'(r_t0a4) + t_torque'(r_t0b4) + t_torque'(r_t0c4)
                       - t_torque'(r_t0d4);
            r_torq[1] <= t_torque'(r_t1a4) + t_torque'(r_t1b4) + t_torque'(r_t1c4);
            r_torq[2] <= t_torque'(r_t2a4) - t_torque'(r_t2b4);
            r_torq[3] <= t_torque'(r_t3a4) + t_torque'(r_t3b4) + t_torque'(r_t3c4);
        end
    end

    assign o_torque = r_torq;
    assign o_angle  = r_ang[TORQUE_LAT-1];
endmodule
`default_nettype wire

// ===== rtl/agcs_div.sv =====
// Pipelined restoring divider lane that turns one joint torque into a rounded angle offset.
`default_nettype none
module agcs_div #(
    parameter int AW = agcs_pkg::ANGLE_WIDTH_DEF,
    parameter int QW = AW + 9
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  agcs_pkg::t_torque    i_torque,
    input  agcs_pkg::t_stiff     i_stiff,
    input  logic signed [AW-1:0] i_angle,
    output logic [QW-1:0]        o_quot,
    output logic                 o_neg,
    output logic signed [AW-1:0] o_angle
);
    import agcs_pkg::*;

    localparam int SH = 33 - AW;

    logic [DIV_DW-1:0]    r_rem [QW+1];
    logic [DIV_DW-1:0]    r_dvs [QW+1];
    logic [QW-1:0]        r_num [QW+1];
    logic [QW-1:0]        r_q   [QW+1];
    logic                 r_neg [QW+1];
    logic signed [AW-1:0] r_ang [QW+1];

    t_stiff            k_eff;
    logic [DIV_DW-1:0] den;
    logic [TORQ_W-1:0] mag;
    logic [DIV_NW-1:0] num;

    always_comb begin
        k_eff = (i_stiff == '0) ? t_stiff'(1) : i_stiff;
        den   = DIV_DW'(k_eff) << SH;
        mag   = i_torque[TORQ_W-1] ? TORQ_W'(-i_torque) : TORQ_W'(i_torque);
        num   = (DIV_NW'(mag) << 9) + DIV_NW'(den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DIV_DW'(num >> QW);
            r_dvs[0] <= den << 1;
            r_num[0] <= num[QW-1:0];
            r_q[0]   <= '0;
            r_neg[0] <= i_torque[TORQ_W-1];
            r_ang[0] <= i_angle;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_step
        logic [DIV_DW:0] trial;
        logic            qbit;
        assign trial = {r_rem[i], r_num[i][QW-1-i]};
        assign qbit  = (trial >= {1'b0, r_dvs[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= qbit ? DIV_DW'(trial - {1'b0, r_dvs[i]}) : trial[DIV_DW-1:0];
                r_q[i+1]   <= {r_q[i][QW-2:0], qbit};
                r_dvs[i+1] <= r_dvs[i];
                r_num[i+1] <= r_num[i];
                r_neg[i+1] <= r_neg[i];
                r_ang[i+1] <= r_ang[i];
            end
        end
    end

    assign o_quot  = r_q[QW];
    assign o_neg   = r_neg[QW];
    assign o_angle = r_ang[QW];
endmodule
`default_nettype wire

// ===== rtl/agcs_merge.sv =====
// Output stage that applies the offsets, saturates each lane and merges the flags.
`default_nettype none
module agcs_merge #(
    parameter int AW = agcs_pkg::ANGLE_WIDTH_DEF,
    parameter int QW = AW + 9
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [QW-1:0]        i_quot  [agcs_pkg::N_JOINTS],
    input  logic                 i_neg   [agcs_pkg::N_JOINTS],
    input  logic signed [AW-1:0] i_angle [agcs_pkg::N_JOINTS],
    output logic signed [AW-1:0] o_comp  [agcs_pkg::N_JOINTS],
    output logic                 o_sat
);
    import agcs_pkg::*;

    localparam int RW = QW + 2;
    localparam logic signed [RW-1:0] R_MAX = RW'({1'b0, {(AW-1){1'b1}}});
    localparam logic signed [RW-1:0] R_MIN = -R_MAX - RW'(1);

    logic signed [RW-1:0] off  [N_JOINTS];
    logic signed [RW-1:0] diff [N_JOINTS];
    logic signed [AW-1:0] n_comp [N_JOINTS];
    logic [N_JOINTS-1:0]  lane_sat;
    logic signed [AW-1:0] r_comp [N_JOINTS];
    logic                 r_sat;

    always_comb begin
        for (int j = 0; j < N_JOINTS; j++) begin
            off[j]  = i_neg[j] ? -RW'(i_quot[j]) : RW'(i_quot[j]);
            diff[j] = RW'(i_angle[j]) - off[j];
            if (diff[j] > R_MAX) begin
                n_comp[j]   = R_MAX[AW-1:0];
                lane_sat[j] = 1'b1;
            end else if (diff[j] < R_MIN) begin
                n_comp[j]   = R_MIN[AW-1:0];
                lane_sat[j] = 1'b1;
            end else begin
                n_comp[j]   = diff[j][AW-1:0];
                lane_sat[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_comp <= n_comp;
            r_sat  <= |lane_sat;
        end
    end

    assign o_comp = r_comp;
    assign o_sat  = r_sat;
endmodule
`default_nettype wire

// ===== rtl/arm_gravity_compensated_setpoint.sv =====
// Top level of the gravity-compensated setpoint block for a four-joint elastic arm.
// Each transaction carries four joint angles and returns each angle minus its gravity torque
// divided by the joint stiffness, with a flag when any result was clipped. The block is fully
// pipelined: one transaction is accepted per cycle while the output is not stalled, and each
// passes through the 30-step CORDIC lanes, the four multiplier levels of the torque stage,
// the one-bit-per-stage divider lanes and the merge register. A stalled output holds the
// whole pipeline. Stiffness registers are written through the configuration port.
// The user must write them only while no transaction is in flight; this is not enforced.
`default_nettype none
module arm_gravity_compensated_setpoint #(
    parameter int ANGLE_WIDTH = agcs_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    agcs_in_if.sink                  in_ch,
    agcs_out_if.source               out_ch,
    input  logic                     i_cfg_we,
    input  agcs_pkg::t_cfg_idx       i_cfg_idx,
    input  agcs_pkg::t_stiff         i_cfg_data
);
    import agcs_pkg::*;

    localparam int AW  = ANGLE_WIDTH;
    localparam int QW  = AW + 9;
    localparam int LAT = CORDIC_LAT + TORQUE_LAT + QW + 2;
    localparam logic signed [AW-1:0] ANG_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ANG_MIN = {1'b1, {(AW-1){1'b0}}};

    t_stiff               r_stiff [N_JOINTS];
    logic [LAT-1:0]       r_vld;
    logic                 en;

    logic signed [AW-1:0] in_ang  [N_JOINTS];
    t_trig                cs_cos  [N_JOINTS];
    t_trig                cs_sin  [N_JOINTS];
    logic signed [AW-1:0] cs_ang  [N_JOINTS];
    t_torque              tq_val  [N_JOINTS];
    logic signed [AW-1:0] tq_ang  [N_JOINTS];
    logic [QW-1:0]        dv_quot [N_JOINTS];
    logic                 dv_neg  [N_JOINTS];
    logic signed [AW-1:0] dv_ang  [N_JOINTS];
    logic signed [AW-1:0] mg_comp [N_JOINTS];
    logic                 mg_sat;

    assign en           = !r_vld[LAT-1] || out_ch.ready;
    assign in_ch.ready  = en;
    assign out_ch.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int j = 0; j < N_JOINTS; j++) begin
                r_stiff[j] <= STIFF_RESET;
            end
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], in_ch.valid};
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_STIFF_J1: r_stiff[0] <= i_cfg_data;
                    REG_STIFF_J2: r_stiff[1] <= i_cfg_data;
                    REG_STIFF_J3: r_stiff[2] <= i_cfg_data;
                    REG_STIFF_J4: r_stiff[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign in_ang[0] = in_ch.angle_1;
    assign in_ang[1] = in_ch.angle_2;
    assign in_ang[2] = in_ch.angle_3;
    assign in_ang[3] = in_ch.angle_4;

    for (genvar j = 0; j < N_JOINTS; j++) begin : g_cordic
        agcs_cordic #(.AW(AW)) u_cordic (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_angle (in_ang[j]),
            .o_cos   (cs_cos[j]),
            .o_sin   (cs_sin[j]),
            .o_angle (cs_ang[j])
        );
    end

    agcs_torque #(.AW(AW)) u_torque (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_cos    (cs_cos),
        .i_sin    (cs_sin),
        .i_angle  (cs_ang),
        .o_torque (tq_val),
        .o_angle  (tq_ang)
    );

    for (genvar j = 0; j < N_JOINTS; j++) begin : g_div
        agcs_div #(.AW(AW), .QW(QW)) u_div (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_torque (tq_val[j]),
            .i_stiff  (r_stiff[j]),
            .i_angle  (tq_ang[j]),
            .o_quot   (dv_quot[j]),
            .o_neg    (dv_neg[j]),
            .o_angle  (dv_ang[j])
        );
    end

    agcs_merge #(.AW(AW), .QW(QW)) u_merge (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_quot  (dv_quot),
        .i_neg   (dv_neg),
        .i_angle (dv_ang),
        .o_comp  (mg_comp),
        .o_sat   (mg_sat)
    );

    assign out_ch.comp_1    = mg_comp[0];
    assign out_ch.comp_2    = mg_comp[1];
    assign out_ch.comp_3    = mg_comp[2];
    assign out_ch.comp_4    = mg_comp[3];
    assign out_ch.saturated = mg_sat;

`ifndef SYNTHESIS
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.saturated |->
            out_ch.comp_1 == ANG_MAX || out_ch.comp_1 == ANG_MIN ||
            out_ch.comp_2 == ANG_MAX || out_ch.comp_2 == ANG_MIN ||
            out_ch.comp_3 == ANG_MAX || out_ch.comp_3 == ANG_MIN ||
            out_ch.comp_4 == ANG_MAX || out_ch.comp_4 == ANG_MIN)
        else $error("Saturation flag set without a clipped angle.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("Input stalled while the output register is empty.");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ch.ready |=> r_vld[0])
        else $error("Accepted transaction did not enter the pipeline.");
`endif
endmodule
`default_nettype wire
